// ===== rtl/core/soag_pkg.sv =====
// shared types and constants for the spiral order address generator
`timescale 1ns / 1ps

package soag_pkg;

  localparam int unsigned IDX_W        = 6;
  localparam int unsigned SIZE_W       = 7;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned MAX_SIZE_DEF = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd4;

  typedef enum logic [4:0] {
    LEG_0      = 5'b00001,
    LEG_1      = 5'b00010,
    LEG_2      = 5'b00100,
    LEG_3      = 5'b01000,
    LEG_CENTRE = 5'b10000
  } leg_e;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } addr_t;

endpackage

// ===== rtl/core/soag_walker.sv =====
// spiral walk state, size register and address computation
`timescale 1ns / 1ps

module soag_walker #(
  parameter int unsigned MAX_SIZE = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [soag_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                        step_i,
  output soag_pkg::addr_t             addr_o
);
  import soag_pkg::*;

  localparam int unsigned EFF_MAX = (MAX_SIZE < 127) ? MAX_SIZE : 127;
  localparam int unsigned N_W     = $clog2(EFF_MAX + 1);
  localparam int unsigned CNT_RAW = $clog2(EFF_MAX * EFF_MAX);
  localparam int unsigned COUNT_W = (CNT_RAW < 1) ? 1 : CNT_RAW;
  localparam int unsigned AW      = (N_W + 1 > IDX_W) ? N_W + 1 : IDX_W;
  localparam logic [SIZE_W-1:0] EFF_MAX_S = SIZE_W'(EFF_MAX);

  function automatic logic [N_W-1:0] side_of(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] t;
    t = s;
    if (s == '0) begin
      t = SIZE_W'(1);
    end else if (s > EFF_MAX_S) begin
      t = EFF_MAX_S;
    end
    return N_W'(t);
  endfunction

  logic [SIZE_W-1:0]  size_q;
  logic [N_W-1:0]     ring_q, ring_d;
  leg_e               leg_q, leg_d;
  logic [N_W-1:0]     pos_q, pos_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic [N_W-1:0]   n;
  logic [N_W-1:0]   cfg_n;
  logic [2*N_W-1:0] sq_w, last_w;
  logic [AW-1:0]    n_a, c_a, r_a, p_a, two_r, far_a;
  logic [AW-1:0]    row_a, col_a, len_a, p_inc;
  logic             fin;
  leg_e             leg_start;
  leg_e             cfg_leg;

  assign n      = side_of(size_q);
  assign sq_w   = {{N_W{1'b0}}, n} * {{N_W{1'b0}}, n};
  assign last_w = sq_w - {{(2*N_W-1){1'b0}}, 1'b1};
  assign fin    = (count_q == last_w[COUNT_W-1:0]);

  assign n_a   = AW'(n);
  assign c_a   = n_a >> 1;
  assign r_a   = AW'(ring_q);
  assign p_a   = AW'(pos_q);
  assign two_r = r_a << 1;
  assign far_a = n_a - AW'(1) - r_a;
  assign p_inc = p_a + AW'(1);

  assign leg_start = n[0] ? LEG_CENTRE : LEG_0;
  assign cfg_n     = side_of(cfg_wdata_i);
  assign cfg_leg   = cfg_n[0] ? LEG_CENTRE : LEG_0;

  always_comb begin
    row_a = '0;
    col_a = '0;
    len_a = AW'(1);
    if (!n[0]) begin
      len_a = n_a - AW'(1) - two_r;
      case (leg_q)
        LEG_0: begin
          row_a = r_a;
          col_a = r_a + p_a;
        end
        LEG_1: begin
          row_a = r_a + p_a;
          col_a = far_a;
        end
        LEG_2: begin
          row_a = far_a;
          col_a = far_a - p_a;
        end
        default: begin
          row_a = far_a - p_a;
          col_a = r_a;
        end
      endcase
    end else begin
      case (leg_q)
        LEG_0: begin
          len_a = two_r + AW'(1);
          row_a = c_a - r_a + p_a;
          col_a = c_a - AW'(1) - r_a;
        end
        LEG_1: begin
          len_a = two_r + AW'(2);
          row_a = c_a + AW'(1) + r_a;
          col_a = c_a - AW'(1) - r_a + p_a;
        end
        LEG_2: begin
          len_a = two_r + AW'(2);
          row_a = c_a + AW'(1) + r_a - p_a;
          col_a = c_a + AW'(1) + r_a;
        end
        LEG_3: begin
          len_a = two_r + AW'(3);
          row_a = c_a - AW'(1) - r_a;
          col_a = c_a + AW'(1) + r_a - p_a;
        end
        default: begin
          len_a = AW'(1);
          row_a = c_a;
          col_a = c_a;
        end
      endcase
    end
  end

  always_comb begin
    ring_d  = ring_q;
    leg_d   = leg_q;
    pos_d   = pos_q;
    count_d = count_q;
    if (fin) begin
      ring_d  = '0;
      leg_d   = leg_start;
      pos_d   = '0;
      count_d = '0;
    end else begin
      count_d = count_q + COUNT_W'(1);
      if (p_inc >= len_a) begin
        pos_d = '0;
        case (leg_q)
          LEG_CENTRE: begin
            leg_d  = LEG_0;
            ring_d = '0;
          end
          LEG_3: begin
            leg_d  = LEG_0;
            ring_d = ring_q + N_W'(1);
          end
          LEG_0:   leg_d = LEG_1;
          LEG_1:   leg_d = LEG_2;
          LEG_2:   leg_d = LEG_3;
          default: leg_d = LEG_0;
        endcase
      end else begin
        pos_d = p_inc[N_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RESET;
      ring_q  <= '0;
      leg_q   <= LEG_0;
      pos_q   <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      size_q  <= cfg_wdata_i;
      ring_q  <= '0;
      leg_q   <= cfg_leg;
      pos_q   <= '0;
      count_q <= '0;
    end else if (step_i) begin
      ring_q  <= ring_d;
      leg_q   <= leg_d;
      pos_q   <= pos_d;
      count_q <= count_d;
    end
  end

  assign addr_o.row  = row_a[IDX_W-1:0];
  assign addr_o.col  = col_a[IDX_W-1:0];
  assign addr_o.last = fin;

  a_pos_in_leg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_a < len_a)
    else $error("leg position beyond leg length");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= last_w[COUNT_W-1:0])
    else $error("element count beyond matrix area");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fin && !cfg_we_i) |=> (count_q == '0 && pos_q == '0 && ring_q == '0))
    else $error("walk did not restart after final element");

endmodule

// ===== rtl/core/soag_out_stage.sv =====
// result register with valid/stall handshake
`timescale 1ns / 1ps

module soag_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [soag_pkg::DATA_W-1:0] data_i,
  input  soag_pkg::addr_t             addr_i,
  output logic                        accept_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [soag_pkg::IDX_W-1:0]  row_o,
  output logic [soag_pkg::IDX_W-1:0]  col_o,
  output logic [soag_pkg::DATA_W-1:0] data_o,
  output logic                        last_o
);
  import soag_pkg::*;

  logic              valid_q;
  logic [DATA_W-1:0] data_q;
  addr_t             addr_q;
  logic              accept;

  assign in_stall_o = valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign accept_o   = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_i;
      addr_q <= addr_i;
    end
  end

  assign out_valid_o = valid_q;
  assign row_o       = addr_q.row;
  assign col_o       = addr_q.col;
  assign data_o      = data_q;
  assign last_o      = addr_q.last;

  a_accept_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q)
    else $error("accepted transaction not presented");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> valid_q)
    else $error("input stalled while result register empty");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_stall_i && !accept) |=> !valid_q)
    else $error("result repeated after delivery");

endmodule

// ===== rtl/core/spiral_order_address_generator_unit.sv =====
// top level of the spiral order address generator
// an accepted input transaction is shown on the output register in the next cycle
// throughput: one transaction per cycle while the input is not stalled, with the walk counter updated on each accept
// the input stalls only while a result is held and the output is stalled
// reset: asynchronous active low, size 4, walk at top-left corner, output empty
`timescale 1ns / 1ps

module spiral_order_address_generator_unit #(
  parameter int unsigned MAX_SIZE = soag_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [soag_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [soag_pkg::DATA_W-1:0] data_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [soag_pkg::IDX_W-1:0]  row_index_o,
  output logic [soag_pkg::IDX_W-1:0]  column_index_o,
  output logic [soag_pkg::DATA_W-1:0] element_value_o,
  output logic                        final_element_o
);
  import soag_pkg::*;

  addr_t addr;
  logic  accept;

  soag_walker #(
    .MAX_SIZE (MAX_SIZE)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (accept),
    .addr_o      (addr)
  );

  soag_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_i      (data_word_i),
    .addr_i      (addr),
    .accept_o    (accept),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_o       (row_index_o),
    .col_o       (column_index_o),
    .data_o      (element_value_o),
    .last_o      (final_element_o)
  );

endmodule
